// ===== rtl/dbmt_pkg.sv =====
package dbmt_pkg;

    // Input word opcodes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Link state codes.
    localparam logic [1:0] LINK_CONNECTED   = 2'd0;
    localparam logic [1:0] LINK_ADVERTISING = 2'd1;

    // Mode codes.
    localparam logic MODE_LINK   = 1'b0;
    localparam logic MODE_DETECT = 1'b1;

    // Register indexes (byte address divided by four).
    localparam int unsigned REG_IDX_W = 2;
    localparam int unsigned PADDR_W   = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_POLL_PERIOD   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_THR  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOCKOUT_TICKS = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SEND_PERIOD   = 2'd3;

    // Reset values.
    localparam logic [7:0]  RST_POLL_PERIOD   = 8'd10;
    localparam logic [7:0]  RST_DEBOUNCE_THR  = 8'd5;
    localparam logic [15:0] RST_LOCKOUT_TICKS = 16'd5000;
    localparam logic [15:0] RST_SEND_PERIOD   = 16'd400;

    typedef struct packed {
        logic [7:0]  poll_period;
        logic [7:0]  debounce_threshold;
        logic [15:0] lockout_ticks;
        logic [15:0] send_period;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  poll_count;
        logic [7:0]  press_count;
        logic [7:0]  release_count;
        logic        press_seen;
        logic        mode;
        logic [31:0] last_change_time;
        logic [31:0] tick_time;
        logic [15:0] send_count;
        logic [31:0] countdown;
    } t_state;

    typedef struct packed {
        logic        mode;
        logic        disconnect_req;
        logic        detect_start;
        logic        send_req;
        logic        countdown_zero;
        logic [31:0] time_now;
    } t_result;

endpackage

// ===== rtl/dbmt_step.sv =====
module dbmt_step
    import dbmt_pkg::*;
(
    input  t_state      i_state,
    input  t_cfg        i_cfg,
    input  logic        i_op,
    input  logic        i_button_level,
    input  logic [1:0]  i_link_state,
    input  logic [31:0] i_load_value,
    output t_state      o_state,
    output t_result     o_result
);

    logic        sample;
    logic        press_qual;
    logic        release_qual;
    logic [7:0]  press_inc;
    logic [7:0]  release_inc;
    logic        accepted;
    logic [31:0] limit;
    logic        disc;
    logic        dstart;
    logic        sreq;

    assign sample       = (i_state.poll_count == 8'd0);
    assign press_qual   = !i_state.press_seen && !i_button_level;
    assign release_qual = i_state.press_seen && i_button_level;
    assign press_inc    = i_state.press_count + 8'd1;
    assign release_inc  = i_state.release_count + 8'd1;
    assign accepted     = sample && release_qual && (release_inc >= i_cfg.debounce_threshold);
    assign limit        = i_state.last_change_time + {16'd0, i_cfg.lockout_ticks};

    always_comb begin
        o_state = i_state;
        disc    = 1'b0;
        dstart  = 1'b0;
        sreq    = 1'b0;
        if (i_op == OP_LOAD) begin
            o_state.countdown = i_load_value;
        end else begin
            if (!sample) begin
                o_state.poll_count = i_state.poll_count - 8'd1;
            end else begin
                o_state.poll_count = i_cfg.poll_period;
                // A press and a release cannot qualify on the same sample,
                // so both tests use the press flag from before this step.
                if (press_qual) begin
                    o_state.press_count = press_inc;
                    if (press_inc >= i_cfg.debounce_threshold) begin
                        o_state.press_seen = 1'b1;
                    end
                end else begin
                    o_state.press_count = 8'd0;
                end
                if (release_qual) begin
                    o_state.release_count = release_inc;
                    if (accepted) begin
                        o_state.press_seen = 1'b0;
                    end
                end else begin
                    o_state.release_count = 8'd0;
                end
                if (accepted && (i_state.tick_time > limit)) begin
                    o_state.last_change_time = i_state.tick_time;
                    if (i_state.mode == MODE_LINK) begin
                        if (i_link_state == LINK_CONNECTED) begin
                            disc = 1'b1;
                        end else if (i_link_state == LINK_ADVERTISING) begin
                            o_state.mode = MODE_DETECT;
                            dstart       = 1'b1;
                        end
                    end else begin
                        o_state.mode = MODE_LINK;
                    end
                end
            end
            if (i_state.countdown != 32'd0) begin
                o_state.countdown = i_state.countdown - 32'd1;
            end
            o_state.tick_time = i_state.tick_time + 32'd1;
            if (i_state.send_count != 16'd0) begin
                o_state.send_count = i_state.send_count - 16'd1;
            end else begin
                sreq               = 1'b1;
                o_state.send_count = i_cfg.send_period;
            end
        end
    end

    always_comb begin
        o_result.mode           = o_state.mode;
        o_result.disconnect_req = disc;
        o_result.detect_start   = dstart;
        o_result.send_req       = sreq;
        o_result.countdown_zero = (o_state.countdown == 32'd0);
        o_result.time_now       = o_state.tick_time;
    end

endmodule

// ===== rtl/debounced_button_mode_ticker.sv =====
// Debounced button mode ticker.
//
// Each input word is either a one millisecond tick (op = 0) or a load of the
// countdown (op = 1). Every accepted word yields exactly one result word with
// the current mode, the disconnect, detect start and send pulses, the
// countdown zero flag and the timestamp after that step.
// Input and output channels use a valid/ready handshake. A word is captured
// in an input register, and the full step is evaluated combinationally
// between that register and the result register, which holds the result
// until the receiver takes it. Throughput is one word per cycle while the
// receiver does not stall.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more word; after that o_ready drops until the
// receiver takes the waiting result.
// The APB port holds four registers at byte addresses 0, 4, 8 and 12:
// poll period, debounce threshold, lockout ticks and send period. Writes are
// meant to happen while the block is idle; reads return the current values.
// A synchronous active-low reset returns all counters, the mode and the
// registers to their defaults and empties both pipeline registers.
module debounced_button_mode_ticker
    import dbmt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic               i_button_level,
    input  logic [1:0]         i_link_state,
    input  logic [31:0]        i_load_value,

    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_mode,
    output logic               o_disconnect_req,
    output logic               o_detect_start,
    output logic               o_send_req,
    output logic               o_countdown_zero,
    output logic [31:0]        o_time_now,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg        r_cfg;
    t_state      r_state;
    t_state      n_state;
    t_result     n_result;
    t_result     r_result;

    logic        r_in_valid;
    logic        r_in_op;
    logic        r_in_level;
    logic [1:0]  r_in_link;
    logic [31:0] r_in_load;
    logic        r_out_valid;

    logic        advance;
    logic        cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    // The step advances when a word waits in the input register and the
    // result register is empty or being emptied in this cycle.
    assign advance   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || advance;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[PADDR_W-1:2];

    dbmt_step u_step (
        .i_state        (r_state),
        .i_cfg          (r_cfg),
        .i_op           (r_in_op),
        .i_button_level (r_in_level),
        .i_link_state   (r_in_link),
        .i_load_value   (r_in_load),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_period        <= RST_POLL_PERIOD;
            r_cfg.debounce_threshold <= RST_DEBOUNCE_THR;
            r_cfg.lockout_ticks      <= RST_LOCKOUT_TICKS;
            r_cfg.send_period        <= RST_SEND_PERIOD;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_POLL_PERIOD:   r_cfg.poll_period        <= pwdata[7:0];
                REG_DEBOUNCE_THR:  r_cfg.debounce_threshold <= pwdata[7:0];
                REG_LOCKOUT_TICKS: r_cfg.lockout_ticks      <= pwdata[15:0];
                REG_SEND_PERIOD:   r_cfg.send_period        <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_POLL_PERIOD:   prdata = {24'd0, r_cfg.poll_period};
            REG_DEBOUNCE_THR:  prdata = {24'd0, r_cfg.debounce_threshold};
            REG_LOCKOUT_TICKS: prdata = {16'd0, r_cfg.lockout_ticks};
            REG_SEND_PERIOD:   prdata = {16'd0, r_cfg.send_period};
            default:           prdata = 32'd0;
        endcase
    end

    // Block state: the poll prescaler starts at its default reload value
    // and the send divider at its default period.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.poll_count       <= RST_POLL_PERIOD;
            r_state.press_count      <= 8'd0;
            r_state.release_count    <= 8'd0;
            r_state.press_seen       <= 1'b0;
            r_state.mode             <= MODE_LINK;
            r_state.last_change_time <= 32'd0;
            r_state.tick_time        <= 32'd0;
            r_state.send_count       <= RST_SEND_PERIOD;
            r_state.countdown        <= 32'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_op    <= i_op;
            r_in_level <= i_button_level;
            r_in_link  <= i_link_state;
            r_in_load  <= i_load_value;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_mode           = r_result.mode;
    assign o_disconnect_req = r_result.disconnect_req;
    assign o_detect_start   = r_result.detect_start;
    assign o_send_req       = r_result.send_req;
    assign o_countdown_zero = r_result.countdown_zero;
    assign o_time_now       = r_result.time_now;

endmodule

// ===== sim/debounced_button_mode_ticker_test.sv =====
`timescale 1ns / 1ps

module debounced_button_mode_ticker_test;
    import dbmt_pkg::*;

    // Link states that the block treats as neither connected nor advertising.
    localparam logic [1:0] LINK_OTHER = 2'd2;
    localparam logic [1:0] LINK_SPARE = 2'd3;

    // Cycles that the receiver refuses results in the back-pressure test.
    localparam int HOLD_CYCLES = 400;
    // Cycles without any word moving on either channel before the run is abandoned.
    localparam int QUIET_LIMIT = 5000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_op = OP_TICK;
    logic               i_button_level = 1'b1;
    logic [1:0]         i_link_state = LINK_OTHER;
    logic [31:0]        i_load_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_mode;
    logic               o_disconnect_req;
    logic               o_detect_start;
    logic               o_send_req;
    logic               o_countdown_zero;
    logic [31:0]        o_time_now;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    debounced_button_mode_ticker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_button_level   (i_button_level),
        .i_link_state     (i_link_state),
        .i_load_value     (i_load_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_mode           (o_mode),
        .o_disconnect_req (o_disconnect_req),
        .o_detect_start   (o_detect_start),
        .o_send_req       (o_send_req),
        .o_countdown_zero (o_countdown_zero),
        .o_time_now       (o_time_now),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 4 ns clock period.
    always #2 i_clk = ~i_clk;

    // The testbench's own copy of the registers. It only changes while the
    // block is idle, so the prediction can use it at the moment a word is taken.
    t_cfg cfg_shadow = '{
        poll_period:        RST_POLL_PERIOD,
        debounce_threshold: RST_DEBOUNCE_THR,
        lockout_ticks:      RST_LOCKOUT_TICKS,
        send_period:        RST_SEND_PERIOD
    };

    // Predicted state of the ticker, starting from its reset values.
    logic [7:0]  poll_left         = RST_POLL_PERIOD;
    logic [7:0]  press_run         = '0;
    logic [7:0]  release_run       = '0;
    logic        press_latched     = 1'b0;
    logic        mode_now          = MODE_LINK;
    logic [31:0] last_change_stamp = '0;
    logic [31:0] stamp             = '0;
    logic [15:0] send_left         = RST_SEND_PERIOD;
    logic [31:0] countdown_now     = '0;

    // Results that the block owes us, oldest first.
    t_result pending_results[$];

    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_taken     = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // Advances the predicted ticker by one input word and returns the result
    // word that the block must produce for it.
    function automatic t_result advance_ticker(input logic op, input logic level,
                                               input logic [1:0] link,
                                               input logic [31:0] load_val);
        t_result     res;
        logic        release_taken;
        logic [31:0] window_end;
        res = '0;
        release_taken = 1'b0;
        if (op == OP_LOAD) begin
            // A load only replaces the countdown; time and pulses stand still.
            countdown_now = load_val;
        end else begin
            if (poll_left != 8'd0) begin
                poll_left = poll_left - 8'd1;
            end else begin
                // Press and release are qualified on the same sample, press first.
                if (!press_latched && level == 1'b0) begin
                    press_run = press_run + 8'd1;
                    if (press_run >= cfg_shadow.debounce_threshold) begin
                        press_latched = 1'b1;
                    end
                end else begin
                    press_run = '0;
                end
                if (press_latched && level == 1'b1) begin
                    release_run = release_run + 8'd1;
                    if (release_run >= cfg_shadow.debounce_threshold) begin
                        release_taken = 1'b1;
                        press_latched = 1'b0;
                    end
                end else begin
                    release_run = '0;
                end
                // The lockout window wraps at 32 bits, like the timestamp.
                window_end = last_change_stamp + {16'd0, cfg_shadow.lockout_ticks};
                if (release_taken && stamp > window_end) begin
                    if (mode_now == MODE_DETECT) begin
                        mode_now = MODE_LINK;
                    end else if (link == LINK_CONNECTED) begin
                        res.disconnect_req = 1'b1;
                    end else if (link == LINK_ADVERTISING) begin
                        mode_now = MODE_DETECT;
                        res.detect_start = 1'b1;
                    end
                    last_change_stamp = stamp;
                end
                poll_left = cfg_shadow.poll_period;
            end
            if (countdown_now != 32'd0) begin
                countdown_now = countdown_now - 32'd1;
            end
            stamp = stamp + 32'd1;
            if (send_left != 16'd0) begin
                send_left = send_left - 16'd1;
            end else begin
                res.send_req = 1'b1;
                send_left = cfg_shadow.send_period;
            end
        end
        res.mode = mode_now;
        res.countdown_zero = (countdown_now == 32'd0);
        res.time_now = stamp;
        return res;
    endfunction

    function automatic logic [31:0] shadow_register(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_POLL_PERIOD:   return {24'd0, cfg_shadow.poll_period};
            REG_DEBOUNCE_THR:  return {24'd0, cfg_shadow.debounce_threshold};
            REG_LOCKOUT_TICKS: return {16'd0, cfg_shadow.lockout_ticks};
            default:           return {16'd0, cfg_shadow.send_period};
        endcase
    endfunction

    // APB write: setup cycle, access cycle, then idle, so that a
    // following transfer never reassigns psel in the same time step.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_POLL_PERIOD:   cfg_shadow.poll_period        = value[7:0];
            REG_DEBOUNCE_THR:  cfg_shadow.debounce_threshold = value[7:0];
            REG_LOCKOUT_TICKS: cfg_shadow.lockout_ticks      = value[15:0];
            default:           cfg_shadow.send_period        = value[15:0];
        endcase
        @(posedge i_clk);
    endtask

    // APB read of one register, checked against the shadow copy.
    task automatic reg_check(input logic [REG_IDX_W-1:0] idx);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== shadow_register(idx)) begin
            report_mismatch($sformatf("register %0d readback", idx), got, shadow_register(idx));
        end
        @(posedge i_clk);
    endtask

    // Writes all four registers and reads each one back.
    task automatic apply_config(input t_cfg setting);
        reg_write(REG_POLL_PERIOD,   {24'd0, setting.poll_period});
        reg_write(REG_DEBOUNCE_THR,  {24'd0, setting.debounce_threshold});
        reg_write(REG_LOCKOUT_TICKS, {16'd0, setting.lockout_ticks});
        reg_write(REG_SEND_PERIOD,   {16'd0, setting.send_period});
        reg_check(REG_POLL_PERIOD);
        reg_check(REG_DEBOUNCE_THR);
        reg_check(REG_LOCKOUT_TICKS);
        reg_check(REG_SEND_PERIOD);
    endtask

    // Offers one word and returns in the time step of the edge that took it.
    // Valid is left high so that a following word can go out back to back.
    task automatic send_word(input logic op, input logic level, input logic [1:0] link,
                             input logic [31:0] load_val);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_button_level <= level;
        i_link_state   <= link;
        i_load_value   <= load_val;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(advance_ticker(op, level, link, load_val));
    endtask

    // Stops offering words and waits until every owed result has come back,
    // then lets the two pipeline registers empty.
    task automatic settle_block();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Button traffic shaped like real presses: the pin holds a level for
    // long enough to pass the debouncer most of the time, with some runs cut
    // short, single-word glitches, stray link changes and countdown loads.
    task automatic run_button_traffic(input int word_count);
        int          span;
        int          run_left;
        logic        level_now;
        logic        level;
        logic [1:0]  link_now;
        logic [1:0]  link;
        logic [31:0] load_val;
        span = (int'(cfg_shadow.poll_period) + 1) * (int'(cfg_shadow.debounce_threshold) + 1);
        run_left = 0;
        level_now = 1'b1;
        link_now = LINK_ADVERTISING;
        for (int n = 0; n < word_count; n++) begin
            load_val = $urandom;
            if ($urandom_range(15) == 0) begin
                if ($urandom_range(1) == 0) begin
                    load_val = $urandom_range(24);
                end
                send_word(OP_LOAD, 1'($urandom_range(1)), 2'($urandom_range(3)), load_val);
            end else begin
                if (run_left == 0) begin
                    level_now = ~level_now;
                    if (level_now == 1'b0) begin
                        link_now = 2'($urandom_range(3));
                    end
                    if ($urandom_range(4) == 0) begin
                        run_left = $urandom_range(span, 1);
                    end else begin
                        run_left = span + $urandom_range(span);
                    end
                end
                run_left--;
                level = level_now;
                if ($urandom_range(19) == 0) begin
                    level = ~level;
                end
                link = link_now;
                if ($urandom_range(9) == 0) begin
                    link = 2'($urandom_range(3));
                end
                send_word(OP_TICK, level, link, load_val);
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input t_cfg setting,
                             input int word_count);
        settle_block();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        apply_config(setting);
        run_button_traffic(word_count);
    endtask

    // Reset values read back, then every register driven to both ends of its
    // range and restored.
    task automatic test_register_access();
        reg_check(REG_POLL_PERIOD);
        reg_check(REG_DEBOUNCE_THR);
        reg_check(REG_LOCKOUT_TICKS);
        reg_check(REG_SEND_PERIOD);
        apply_config('{8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF});
        apply_config('{8'h00, 8'h00, 16'h0000, 16'h0000});
        apply_config('{RST_POLL_PERIOD, RST_DEBOUNCE_THR, RST_LOCKOUT_TICKS, RST_SEND_PERIOD});
    endtask

    // A short hand-made sequence: countdown loads at both ends, ticks that
    // fall inside the first poll interval, then one accepted release for each
    // link state and mode, a zero threshold and a lockout that blocks a change.
    task automatic test_directed_words();
        apply_config('{8'd0, 8'd1, 16'd0, RST_SEND_PERIOD});
        send_word(OP_LOAD, 1'b1, LINK_SPARE, 32'h0000_0000);
        send_word(OP_LOAD, 1'b0, LINK_OTHER, 32'hFFFF_FFFF);
        send_word(OP_LOAD, 1'b1, LINK_CONNECTED, 32'h0000_0001);
        // The reset poll count of ten is still running, so these are not sampled.
        for (int n = 0; n < 10; n++) begin
            send_word(OP_TICK, 1'b0, 2'(n), 32'hFFFF_FFFF);
        end
        send_word(OP_TICK, 1'b0, LINK_CONNECTED, 32'h0000_0000);
        // Release while connected asks for a disconnect.
        send_word(OP_TICK, 1'b1, LINK_CONNECTED, 32'h0000_0000);
        send_word(OP_TICK, 1'b0, LINK_ADVERTISING, 32'h0000_0000);
        // Release while advertising enters detect mode.
        send_word(OP_TICK, 1'b1, LINK_ADVERTISING, 32'h0000_0000);
        send_word(OP_TICK, 1'b0, LINK_OTHER, 32'h0000_0000);
        // Release in detect mode returns to link mode whatever the link state.
        send_word(OP_TICK, 1'b1, LINK_OTHER, 32'h0000_0000);
        send_word(OP_TICK, 1'b0, LINK_SPARE, 32'h0000_0000);
        // Release in link mode with some other link state changes nothing.
        send_word(OP_TICK, 1'b1, LINK_SPARE, 32'h0000_0000);
        settle_block();
        reg_write(REG_DEBOUNCE_THR, 32'd0);
        send_word(OP_TICK, 1'b0, LINK_ADVERTISING, 32'h0000_0000);
        send_word(OP_TICK, 1'b1, LINK_ADVERTISING, 32'h0000_0000);
        settle_block();
        reg_write(REG_LOCKOUT_TICKS, 32'h0000_FFFF);
        send_word(OP_TICK, 1'b0, LINK_ADVERTISING, 32'h0000_0000);
        send_word(OP_TICK, 1'b1, LINK_ADVERTISING, 32'h0000_0000);
    endtask

    // Sampling every tick with no lockout, so the mode flips as fast as it can.
    task automatic test_fast_toggling();
        run_phase(0, 0, '{8'd0, 8'd1, 16'd0, 16'd0}, 250);
    endtask

    task automatic test_sender_gaps();
        run_phase(73, 0, '{8'd3, 8'd3, 16'd30, 16'd9}, 250);
    endtask

    task automatic test_receiver_stalls();
        run_phase(0, 73, '{8'd1, 8'd2, 16'd12, 16'hFFFF}, 250);
    endtask

    // Zero threshold: every qualifying sample is taken at once.
    task automatic test_mixed_idling();
        run_phase(33, 33, '{8'd0, 8'd0, 16'd3, 16'd1}, 250);
    endtask

    // Largest poll period and threshold: the button is almost never sampled.
    task automatic test_slow_extremes();
        run_phase(0, 0, '{8'hFF, 8'hFF, 16'hFFFF, 16'd0}, 100);
    endtask

    // The receiver refuses results for a long stretch while words keep coming,
    // so both pipeline registers fill and the block must stall its input.
    task automatic test_input_backpressure();
        settle_block();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_config('{8'd0, 8'd2, 16'd5, 16'd4});
        hold_asked++;
        run_button_traffic(40);
    endtask

    // Receiver: random stalls at the phase's rate, or a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Each result word taken is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with none expected", o_time_now, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_mode !== want.mode) begin
                    report_mismatch("mode", o_mode, want.mode);
                end
                if (o_disconnect_req !== want.disconnect_req) begin
                    report_mismatch("disconnect_req", o_disconnect_req, want.disconnect_req);
                end
                if (o_detect_start !== want.detect_start) begin
                    report_mismatch("detect_start", o_detect_start, want.detect_start);
                end
                if (o_send_req !== want.send_req) begin
                    report_mismatch("send_req", o_send_req, want.send_req);
                end
                if (o_countdown_zero !== want.countdown_zero) begin
                    report_mismatch("countdown_zero", o_countdown_zero, want.countdown_zero);
                end
                if (o_time_now !== want.time_now) begin
                    report_mismatch("time_now", o_time_now, want.time_now);
                end
            end
        end
    end

    // Watchdog: a long spell with no word moving on either channel means the
    // block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog expired: no word moved for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_access();
        test_directed_words();
        test_fast_toggling();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_slow_extremes();
        test_input_backpressure();
        settle_block();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
